// File: design/temp_sensor_calibrate_average_core_macros.svh
// Assertion macros shared by the temperature calibrate/average core.
// Expects clk_i and rst_ni in the scope that uses them; no other dependencies.
`ifndef TEMP_SENSOR_CALIBRATE_AVERAGE_CORE_MACROS_SVH
`define TEMP_SENSOR_CALIBRATE_AVERAGE_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define TSCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define TSCA_ASSERT_NEVER(lbl, expr, msg) \
  `TSCA_ASSERT(lbl, !(expr), msg)

`endif

// File: design/tsca_pkg.sv
// Shared constants, widths, sequencer states and divider status type for the
// temperature calibrate/average core. No dependencies.
package tsca_pkg;

  localparam int WINDOW_LEN  = 36;
  localparam int SAMPLE_BITS = 12;

  // result field widths (fixed by the output format)
  localparam int SAMP_W = 13;
  localparam int FAHR_W = 14;

  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMP_W + $clog2(WINDOW_LEN);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int F9_W   = SAMP_W + 4;

  // shared divider: numerator covers 2*|raw-cal30|*880+den and 2*|sum|+len
  localparam int NUM_W = (SAMPLE_BITS + 11 > SUM_W + 2) ? SAMPLE_BITS + 11 : SUM_W + 2;
  localparam int DVS_W = (SAMPLE_BITS + 1 > $clog2(2 * WINDOW_LEN + 1)) ?
                         SAMPLE_BITS + 1 : $clog2(2 * WINDOW_LEN + 1);
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int WIDE_W = NUM_W + 2;

  // stream data widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * SAMP_W + FAHR_W + 7) / 8) * 8;

  // fixed-point constants, sixteenths of a degree
  localparam int CAL_SPAN_16    = 880;   // 55 C
  localparam int CAL_OFFSET_16  = 480;   // 30 C
  localparam int FAHR_NUM       = 9;
  localparam int FAHR_DEN       = 5;
  localparam int FAHR_OFFSET_16 = 512;   // 32 F

  localparam int SAMP_MIN = -(2 ** (SAMP_W - 1));
  localparam int SAMP_MAX = (2 ** (SAMP_W - 1)) - 1;
  localparam int FAHR_MIN = -(2 ** (FAHR_W - 1));
  localparam int FAHR_MAX = (2 ** (FAHR_W - 1)) - 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_30C = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_85C = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMP_START,
    ST_SAMP_WAIT,
    ST_UPDATE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_FAHR_START,
    ST_FAHR_WAIT,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/tsca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tsca_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on tsca_pkg for widths and the status struct.
module tsca_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsca_pkg::NUM_W-1:0]  num_i,
  input  logic [tsca_pkg::DVS_W-1:0]  dvs_i,
  output tsca_pkg::div_stat_t         stat_o,
  output logic [tsca_pkg::NUM_W-1:0]  quo_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [tsca_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [tsca_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [tsca_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [tsca_pkg::NUM_W-1:0] quo_q, quo_d;
  logic [tsca_pkg::DVS_W:0]   shifted;
  logic [tsca_pkg::DVS_W:0]   trial;
  logic                       fits;
  logic                       last;

  assign shifted = {rem_q, quo_q[tsca_pkg::NUM_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = ~trial[tsca_pkg::DVS_W];
  assign last    = (cnt_q == tsca_pkg::CNT_W'(tsca_pkg::NUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q & last;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
      rem_d = fits ? trial[tsca_pkg::DVS_W-1:0] : shifted[tsca_pkg::DVS_W-1:0];
      quo_d = {quo_q[tsca_pkg::NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// File: design/temp_sensor_calibrate_average_core.sv
// Top level: two-point sensor calibration, 36-entry moving average, Fahrenheit.
// Depends on tsca_pkg, tsca_ram, tsca_div and the assertion macro header.
//
//  channel   | direction | signals                          | payload
//  ----------+-----------+----------------------------------+------------------------------
//  s_axis    | in        | tvalid tready tdata[15:0]        | raw_sample
//  m_axis    | out       | tvalid tready tdata[39:0] tuser  | three temperatures, error flag
//  cfg       | in        | cfg_valid/ready, addr, data      | calibration register write
//
// A request runs the shared 23-step divider three times, twice when the calibration is bad.
// The result sits in an output register, so the next request is accepted while it waits.
// rst_ni clears the window (through a wrap flag), the sum and the pointer, and returns the
// calibration words to 0 and 4095.
// A stalled m_axis holds the sequencer in its final state until the register frees up.
`include "temp_sensor_calibrate_average_core_macros.svh"

module temp_sensor_calibrate_average_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // raw_sample [11:0], zero above
  input  logic [tsca_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_celsius [12:0], average_celsius [25:13], average_fahrenheit [39:26]
  output logic [tsca_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // calibration_error [0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tsca_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [tsca_pkg::SAMPLE_BITS-1:0]   cfg_data_i
);

  tsca_pkg::seq_state_e state_q, state_d;

  logic [tsca_pkg::SAMPLE_BITS-1:0]  cal30_q, cal85_q;
  logic [tsca_pkg::POS_W-1:0]        pos_q;
  logic                              wrapped_q;
  logic signed [tsca_pkg::SUM_W-1:0] sum_q, sum_d;

  logic signed [tsca_pkg::DIFF_W-1:0] diff_q;
  logic                               err_q;
  logic                               neg_q;
  logic signed [tsca_pkg::SAMP_W-1:0] samp_q, avg_q;
  logic signed [tsca_pkg::FAHR_W-1:0] fahr_q;

  logic                               out_valid_q;
  logic signed [tsca_pkg::SAMP_W-1:0] out_samp_q, out_avg_q;
  logic signed [tsca_pkg::FAHR_W-1:0] out_fahr_q;
  logic                               out_err_q;

  logic in_req;
  logic out_load;
  logic ram_we;
  logic div_start;
  logic div_wait;
  logic [tsca_pkg::NUM_W-1:0] div_num;
  logic [tsca_pkg::DVS_W-1:0] div_dvs;
  logic [tsca_pkg::NUM_W-1:0] div_quo;
  tsca_pkg::div_stat_t        div_stat;
  logic [tsca_pkg::SAMP_W-1:0] ram_rdata;

  logic signed [tsca_pkg::DIFF_W-1:0] diff_in;
  logic signed [tsca_pkg::DIFF_W-1:0] den_s;
  logic [tsca_pkg::DIFF_W-1:0]        den_u;
  logic [tsca_pkg::DIFF_W-1:0]        diff_mag;
  logic                               cal_bad;
  logic [tsca_pkg::NUM_W-1:0]         samp_prod;
  logic [tsca_pkg::NUM_W-1:0]         samp_num;
  logic [tsca_pkg::DVS_W-1:0]         samp_dvs;
  logic [tsca_pkg::SUM_W-1:0]         sum_mag;
  logic [tsca_pkg::NUM_W-1:0]         avg_num;
  logic signed [tsca_pkg::F9_W-1:0]   avg9;
  logic [tsca_pkg::F9_W-1:0]          avg9_mag;
  logic [tsca_pkg::NUM_W-1:0]         fahr_num;
  logic signed [tsca_pkg::SAMP_W-1:0] old_val;

  logic signed [tsca_pkg::WIDE_W-1:0] q_ext, q_signed, samp_wide, fahr_wide;
  logic signed [tsca_pkg::FAHR_W-1:0] samp_sat, avg_sat, fahr_sat;

  function automatic logic signed [tsca_pkg::FAHR_W-1:0] sat(
    input logic signed [tsca_pkg::WIDE_W-1:0] v,
    input int lo,
    input int hi
  );
    logic signed [tsca_pkg::FAHR_W-1:0] r;
    if (v < tsca_pkg::WIDE_W'(lo)) begin
      r = tsca_pkg::FAHR_W'(lo);
    end else if (v > tsca_pkg::WIDE_W'(hi)) begin
      r = tsca_pkg::FAHR_W'(hi);
    end else begin
      r = tsca_pkg::FAHR_W'(v);
    end
    return r;
  endfunction

  assign in_req      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // ---- arithmetic around the divider ----
  assign diff_in = $signed({1'b0, s_axis_tdata[tsca_pkg::SAMPLE_BITS-1:0]})
                 - $signed({1'b0, cal30_q});
  assign den_s   = $signed({1'b0, cal85_q}) - $signed({1'b0, cal30_q});
  assign den_u   = unsigned'(den_s);
  assign cal_bad = den_s[tsca_pkg::DIFF_W-1] | (den_s == '0);

  assign diff_mag  = diff_q[tsca_pkg::DIFF_W-1] ? unsigned'(-diff_q) : unsigned'(diff_q);
  assign samp_prod = tsca_pkg::NUM_W'(diff_mag) * tsca_pkg::NUM_W'(tsca_pkg::CAL_SPAN_16);
  // round to nearest: (2*mag*880 + den) / (2*den)
  assign samp_num  = {samp_prod[tsca_pkg::NUM_W-2:0], 1'b0} + tsca_pkg::NUM_W'(den_u);
  assign samp_dvs  = tsca_pkg::DVS_W'({den_u, 1'b0});

  assign sum_mag = sum_q[tsca_pkg::SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
  assign avg_num = (tsca_pkg::NUM_W'(sum_mag) << 1) + tsca_pkg::NUM_W'(tsca_pkg::WINDOW_LEN);

  assign avg9     = tsca_pkg::F9_W'(avg_q) * tsca_pkg::F9_W'(tsca_pkg::FAHR_NUM);
  assign avg9_mag = avg9[tsca_pkg::F9_W-1] ? unsigned'(-avg9) : unsigned'(avg9);
  assign fahr_num = (tsca_pkg::NUM_W'(avg9_mag) << 1) + tsca_pkg::NUM_W'(tsca_pkg::FAHR_DEN);

  assign q_ext     = $signed({2'b00, div_quo});
  assign q_signed  = neg_q ? -q_ext : q_ext;
  assign samp_wide = q_signed + tsca_pkg::WIDE_W'(tsca_pkg::CAL_OFFSET_16);
  assign fahr_wide = q_signed + tsca_pkg::WIDE_W'(tsca_pkg::FAHR_OFFSET_16);
  assign samp_sat  = sat(samp_wide, tsca_pkg::SAMP_MIN, tsca_pkg::SAMP_MAX);
  assign avg_sat   = sat(q_signed, tsca_pkg::SAMP_MIN, tsca_pkg::SAMP_MAX);
  assign fahr_sat  = sat(fahr_wide, tsca_pkg::FAHR_MIN, tsca_pkg::FAHR_MAX);

  // ring slot not yet written on the first pass reads as zero
  assign old_val = wrapped_q ? $signed(ram_rdata) : '0;
  assign sum_d   = sum_q - tsca_pkg::SUM_W'(old_val) + tsca_pkg::SUM_W'(samp_q);

  assign div_wait = (state_q == tsca_pkg::ST_SAMP_WAIT) || (state_q == tsca_pkg::ST_AVG_WAIT) ||
                    (state_q == tsca_pkg::ST_FAHR_WAIT);

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsca_pkg::ST_IDLE: begin
        if (in_req) state_d = tsca_pkg::ST_SAMP_START;
      end
      tsca_pkg::ST_SAMP_START: begin
        state_d = err_q ? tsca_pkg::ST_UPDATE : tsca_pkg::ST_SAMP_WAIT;
      end
      tsca_pkg::ST_SAMP_WAIT: begin
        if (div_stat.done) state_d = tsca_pkg::ST_UPDATE;
      end
      tsca_pkg::ST_UPDATE:     state_d = tsca_pkg::ST_AVG_START;
      tsca_pkg::ST_AVG_START:  state_d = tsca_pkg::ST_AVG_WAIT;
      tsca_pkg::ST_AVG_WAIT: begin
        if (div_stat.done) state_d = tsca_pkg::ST_FAHR_START;
      end
      tsca_pkg::ST_FAHR_START: state_d = tsca_pkg::ST_FAHR_WAIT;
      tsca_pkg::ST_FAHR_WAIT: begin
        if (div_stat.done) state_d = tsca_pkg::ST_EMIT;
      end
      tsca_pkg::ST_EMIT: begin
        if (out_load) state_d = tsca_pkg::ST_IDLE;
      end
      default: state_d = tsca_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_num       = samp_num;
    div_dvs       = samp_dvs;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      tsca_pkg::ST_IDLE:       s_axis_tready = 1'b1;
      tsca_pkg::ST_SAMP_START: div_start = ~err_q;
      tsca_pkg::ST_UPDATE:     ram_we = 1'b1;
      tsca_pkg::ST_AVG_START: begin
        div_start = 1'b1;
        div_num   = avg_num;
        div_dvs   = tsca_pkg::DVS_W'(2 * tsca_pkg::WINDOW_LEN);
      end
      tsca_pkg::ST_FAHR_START: begin
        div_start = 1'b1;
        div_num   = fahr_num;
        div_dvs   = tsca_pkg::DVS_W'(2 * tsca_pkg::FAHR_DEN);
      end
      tsca_pkg::ST_EMIT:       out_load = ~out_valid_q | m_axis_tready;
      default: ;
    endcase
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsca_pkg::ST_IDLE;
      cal30_q     <= '0;
      cal85_q     <= '1;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          tsca_pkg::CFG_CAL_30C: cal30_q <= cfg_data_i;
          tsca_pkg::CFG_CAL_85C: cal85_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ram_we) begin
        sum_q <= sum_d;
        if (pos_q == tsca_pkg::POS_W'(tsca_pkg::WINDOW_LEN - 1)) begin
          pos_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      diff_q <= diff_in;
      err_q  <= cal_bad;
    end
    case (state_q)
      tsca_pkg::ST_SAMP_START: begin
        neg_q <= diff_q[tsca_pkg::DIFF_W-1];
        if (err_q) samp_q <= '0;
      end
      tsca_pkg::ST_SAMP_WAIT: begin
        if (div_stat.done) samp_q <= tsca_pkg::SAMP_W'(samp_sat);
      end
      tsca_pkg::ST_AVG_START:  neg_q <= sum_q[tsca_pkg::SUM_W-1];
      tsca_pkg::ST_AVG_WAIT: begin
        if (div_stat.done) avg_q <= tsca_pkg::SAMP_W'(avg_sat);
      end
      tsca_pkg::ST_FAHR_START: neg_q <= avg9[tsca_pkg::F9_W-1];
      tsca_pkg::ST_FAHR_WAIT: begin
        if (div_stat.done) fahr_q <= fahr_sat;
      end
      default: ;
    endcase
    if (out_load) begin
      out_samp_q <= samp_q;
      out_avg_q  <= avg_q;
      out_fahr_q <= fahr_q;
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tsca_pkg::M_TDATA_W'({out_fahr_q, out_avg_q, out_samp_q});
  assign m_axis_tuser  = out_err_q;

  tsca_ram #(
    .WIDTH (tsca_pkg::SAMP_W),
    .DEPTH (tsca_pkg::WINDOW_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (samp_q),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  tsca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .dvs_i   (div_dvs),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  `TSCA_ASSERT(a_pos_range, pos_q <= tsca_pkg::POS_W'(tsca_pkg::WINDOW_LEN - 1), "bad pointer")
  `TSCA_ASSERT(a_start_idle, div_start |-> !div_stat.busy, "divider restarted while busy")
  `TSCA_ASSERT(a_done_wait, div_stat.done |-> div_wait, "divider result not awaited")
  `TSCA_ASSERT_NEVER(a_wrap_sticky, $fell(wrapped_q), "wrap flag cleared outside reset")

endmodule
